// ----- sv/smve_pkg.sv -----
//------------------------------------------------------------------------------
// SML meter value extractor package
// Shared widths, codes and transaction types of the meter value extractor.
//------------------------------------------------------------------------------
`default_nettype none

package smve_pkg;

   // Field widths
   localparam int QUANTITY_W  = 3;
   localparam int VALUE_W     = 32;
   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int TIMEOUT_W   = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   // Default depth of the queue between the parser and the scaler
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Input commands
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Meter layouts
   localparam logic [KIND_W-1:0] KIND_LAYOUT0 = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LAYOUT1 = 2'd1;

   // Configuration register indexes and reset values
   localparam logic [CSR_INDEX_W-1:0] CSR_METER_KIND    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 1'd1;
   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET     = 16'd5000;

   // Result quantities
   localparam logic [QUANTITY_W-1:0] Q_GRID_ENERGY  = 3'd0;
   localparam logic [QUANTITY_W-1:0] Q_SOLAR_ENERGY = 3'd1;
   localparam logic [QUANTITY_W-1:0] Q_GRID_POWER   = 3'd2;
   localparam logic [QUANTITY_W-1:0] Q_SOLAR_POWER  = 3'd3;
   localparam logic [QUANTITY_W-1:0] Q_TIMEOUT      = 3'd4;

   // One unscaled result: the quantity and its sign-extended raw word
   typedef struct packed {
      logic [QUANTITY_W-1:0] quantity;
      logic [VALUE_W-1:0]    raw;
   } smve_item_type;

   // A queue transaction with its valid flag
   typedef struct packed {
      logic          valid;
      smve_item_type item;
   } smve_xfer_type;

endpackage

`default_nettype wire

// ----- sv/smve_if.sv -----
//------------------------------------------------------------------------------
// SML meter value extractor channel interfaces
// Valid/ready channels for input bytes and ticks, results and register writes.
//------------------------------------------------------------------------------
`default_nettype none

// Input channel: received bytes and millisecond ticks
interface smve_req_if import smve_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              command;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink (input valid, input command, input data_byte, output ready);
endinterface

// Result channel: decoded quantities
interface smve_rsp_if import smve_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [QUANTITY_W-1:0]    quantity;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output quantity, output value, input ready);
   modport sink (input valid, input quantity, input value, output ready);
endinterface

// Configuration write channel
interface smve_csr_if import smve_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/smve_front.sv -----
//------------------------------------------------------------------------------
// SML meter value extractor parser
// Accepts bytes and ticks, runs the pattern state machine and the idle timer,
// and pushes unscaled results into the queue.
//------------------------------------------------------------------------------
`default_nettype none

module smve_front import smve_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   smve_req_if.sink     req,
   smve_csr_if.sink     csr,
   input  wire logic    queue_ready,
   output smve_xfer_type push
);

   // Parser steps
   localparam logic [3:0] STEP_START       = 4'd1;
   localparam logic [3:0] STEP_ENERGY_PAT  = 4'd2;
   localparam logic [3:0] STEP_ENERGY_CAP  = 4'd3;
   localparam logic [3:0] STEP_SECOND_PAT  = 4'd4;
   localparam logic [3:0] STEP_SECOND_CAP  = 4'd5;
   localparam logic [3:0] STEP_POWER_PAT   = 4'd6;
   localparam logic [3:0] STEP_POWER_CAP2  = 4'd7;
   localparam logic [3:0] STEP_POWER_CAP3  = 4'd8;

   // Pattern selectors
   localparam logic [2:0] PAT_START     = 3'd0;
   localparam logic [2:0] PAT_L0_ENERGY = 3'd1;
   localparam logic [2:0] PAT_L0_POWER  = 3'd2;
   localparam logic [2:0] PAT_L1_ENERGY = 3'd3;
   localparam logic [2:0] PAT_L1_SOLAR  = 3'd4;
   localparam logic [2:0] PAT_L1_POWER  = 3'd5;

   // Length bytes that select the solar power width
   localparam logic [7:0] LEN_TWO_BYTES   = 8'h53;
   localparam logic [7:0] LEN_THREE_BYTES = 8'h54;

   // Byte patterns
   localparam logic [7:0] START_PAT [8] = '{8'h1B, 8'h1B, 8'h1B, 8'h1B,
                                            8'h01, 8'h01, 8'h01, 8'h01};
   localparam logic [7:0] L0_ENERGY_PAT [23] = '{
      8'h77, 8'h07, 8'h01, 8'h00, 8'h01, 8'h08, 8'h00, 8'hFF, 8'h65, 8'h00, 8'h1C, 8'h81,
      8'h04, 8'h01, 8'h62, 8'h1E, 8'h52, 8'hFF, 8'h69, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] L0_POWER_PAT [19] = '{
      8'h77, 8'h07, 8'h01, 8'h00, 8'h10, 8'h07, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h62, 8'h1B,
      8'h52, 8'h00, 8'h59, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] L1_ENERGY_PAT [25] = '{
      8'h77, 8'h07, 8'h01, 8'h00, 8'h01, 8'h08, 8'h00, 8'hFF, 8'h64, 8'h00, 8'h00, 8'h00,
      8'h72, 8'h62, 8'h01, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h62, 8'h1E, 8'h52, 8'hFF,
      8'h55};
   localparam logic [7:0] L1_SOLAR_PAT [22] = '{
      8'h77, 8'h07, 8'h01, 8'h00, 8'h02, 8'h08, 8'h00, 8'hFF, 8'h01, 8'h72, 8'h62, 8'h01,
      8'h65, 8'h00, 8'h00, 8'h00, 8'h00, 8'h62, 8'h1E, 8'h52, 8'hFF, 8'h55};
   localparam logic [7:0] L1_POWER_PAT [15] = '{
      8'h77, 8'h07, 8'h01, 8'h00, 8'h10, 8'h07, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h62, 8'h1B,
      8'h52, 8'hFE, 8'h00};

   // Length of the selected pattern
   function automatic logic [4:0] pat_length(input logic [2:0] id);
      logic [4:0] len;
      len = 5'd8;
      unique case (id)
         PAT_START:     len = 5'd8;
         PAT_L0_ENERGY: len = 5'd23;
         PAT_L0_POWER:  len = 5'd19;
         PAT_L1_ENERGY: len = 5'd25;
         PAT_L1_SOLAR:  len = 5'd22;
         PAT_L1_POWER:  len = 5'd15;
         default:       len = 5'd8;
      endcase
      return len;
   endfunction

   // Expected byte of the selected pattern; the caller checks the position
   function automatic logic [7:0] pat_byte(input logic [2:0] id, input logic [4:0] pos);
      logic [7:0] b;
      b = 8'h00;
      unique case (id)
         PAT_START:     b = START_PAT[pos[2:0]];
         PAT_L0_ENERGY: b = (pos < 5'd23) ? L0_ENERGY_PAT[pos] : 8'h00;
         PAT_L0_POWER:  b = (pos < 5'd19) ? L0_POWER_PAT[pos] : 8'h00;
         PAT_L1_ENERGY: b = (pos < 5'd25) ? L1_ENERGY_PAT[pos] : 8'h00;
         PAT_L1_SOLAR:  b = (pos < 5'd22) ? L1_SOLAR_PAT[pos] : 8'h00;
         PAT_L1_POWER:  b = (pos < 5'd15) ? L1_POWER_PAT[pos[3:0]] : 8'h00;
         default:       b = 8'h00;
      endcase
      return b;
   endfunction

   logic                  accept;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;
   logic [3:0]            step_ff, step_in;
   logic [3:0]            last_ff, last_in;
   logic [4:0]            pos_ff, pos_in;
   logic [23:0]           cap_ff, cap_in;
   logic [TIMEOUT_W-1:0]  idle_ff, idle_in;
   logic [TIMEOUT_W-1:0]  idle_eff;
   logic [TIMEOUT_W:0]    tick_count;
   logic                  tick_over;
   logic                  layout1;
   logic [2:0]            pat_id;
   logic [4:0]            pat_len;
   logic [7:0]            pat_exp;
   logic                  pat_hit;
   logic                  pat_last;
   logic [4:0]            pat_pos_next;
   logic [5:0]            cap_count;
   logic [5:0]            cap_sum;
   logic                  cap_done;
   logic [4:0]            cap_pos_next;
   logic [31:0]           cap_word;

   assign accept    = req.valid && req.ready;
   assign req.ready = queue_ready;
   assign csr.ready = 1'b1;
   assign layout1   = (kind_ff == KIND_LAYOUT1);

   // Register writes
   always_comb begin
      kind_in    = kind_ff;
      timeout_in = timeout_ff;
      if (csr.valid && csr.ready) begin
         unique case (csr.index)
            CSR_METER_KIND:    kind_in = csr.data[KIND_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_in = csr.data[TIMEOUT_W-1:0];
            default:           ;
         endcase
      end
   end

   // Idle timer: the count restarts when the step has moved since the last item.
   assign idle_eff   = (step_ff != last_ff) ? '0 : idle_ff;
   assign tick_count = {1'b0, idle_eff} + 17'd1;
   assign tick_over  = tick_count > {1'b0, timeout_ff};

   // Pattern selection for the current step
   always_comb begin
      pat_id = PAT_START;
      case (step_ff)
         STEP_ENERGY_PAT: pat_id = layout1 ? PAT_L1_ENERGY : PAT_L0_ENERGY;
         STEP_SECOND_PAT: pat_id = layout1 ? PAT_L1_SOLAR : PAT_L0_POWER;
         STEP_POWER_PAT:  pat_id = PAT_L1_POWER;
         default:         pat_id = PAT_START;
      endcase
   end

   // Pattern compare; in the second layout a zero pattern byte matches anything
   assign pat_len      = pat_length(pat_id);
   assign pat_exp      = pat_byte(pat_id, pos_ff);
   assign pat_hit      = (pos_ff < pat_len) &&
                         ((req.data_byte == pat_exp) || (layout1 && (pat_exp == 8'h00)));
   assign pat_last     = (({1'b0, pos_ff} + 6'd1) == {1'b0, pat_len});
   assign pat_pos_next = (pat_hit && !pat_last) ? pos_ff + 5'd1 : 5'd0;

   // Value capture, big-endian
   always_comb begin
      cap_count = 6'd4;
      case (step_ff)
         STEP_POWER_CAP2: cap_count = 6'd2;
         STEP_POWER_CAP3: cap_count = 6'd3;
         default:         cap_count = 6'd4;
      endcase
   end
   assign cap_word     = {cap_ff, req.data_byte};
   assign cap_sum      = {1'b0, pos_ff} + 6'd1;
   assign cap_done     = cap_sum >= cap_count;
   assign cap_pos_next = cap_done ? 5'd0 : cap_sum[4:0];

   // Step machine
   always_comb begin
      step_in   = step_ff;
      last_in   = last_ff;
      pos_in    = pos_ff;
      cap_in    = cap_ff;
      idle_in   = idle_ff;
      push      = '0;
      if (accept) begin
         last_in = step_ff;
         idle_in = idle_eff;
         if (req.command == CMD_TICK) begin
            if (tick_over) begin
               step_in            = STEP_START;
               pos_in             = 5'd0;
               idle_in            = '0;
               push.valid         = 1'b1;
               push.item.quantity = Q_TIMEOUT;
               push.item.raw      = '0;
            end else begin
               idle_in = tick_count[TIMEOUT_W-1:0];
            end
         end else if ((kind_ff == KIND_LAYOUT0) || (kind_ff == KIND_LAYOUT1)) begin
            unique case (step_ff) inside
               STEP_START: begin
                  pos_in = pat_pos_next;
                  if (pat_hit && pat_last) step_in = STEP_ENERGY_PAT;
               end
               STEP_ENERGY_PAT: begin
                  pos_in = pat_pos_next;
                  if (pat_hit && pat_last) step_in = STEP_ENERGY_CAP;
               end
               STEP_ENERGY_CAP: begin
                  cap_in = cap_word[23:0];
                  pos_in = cap_pos_next;
                  if (cap_done) begin
                     step_in            = STEP_SECOND_PAT;
                     push.valid         = 1'b1;
                     push.item.quantity = Q_GRID_ENERGY;
                     push.item.raw      = cap_word;
                  end
               end
               STEP_SECOND_PAT: begin
                  pos_in = pat_pos_next;
                  if (pat_hit && pat_last) step_in = STEP_SECOND_CAP;
               end
               STEP_SECOND_CAP: begin
                  cap_in = cap_word[23:0];
                  pos_in = cap_pos_next;
                  if (cap_done) begin
                     push.valid    = 1'b1;
                     push.item.raw = cap_word;
                     if (layout1) begin
                        step_in            = STEP_POWER_PAT;
                        push.item.quantity = Q_SOLAR_ENERGY;
                     end else begin
                        step_in            = STEP_START;
                        push.item.quantity = Q_GRID_POWER;
                     end
                  end
               end
               STEP_POWER_PAT: begin
                  if (layout1) begin
                     pos_in = pat_pos_next;
                     if (pat_hit && pat_last) begin
                        if (req.data_byte == LEN_TWO_BYTES) begin
                           step_in = STEP_POWER_CAP2;
                        end else if (req.data_byte == LEN_THREE_BYTES) begin
                           step_in = STEP_POWER_CAP3;
                        end
                     end
                  end
               end
               STEP_POWER_CAP2, STEP_POWER_CAP3: begin
                  if (layout1) begin
                     cap_in = cap_word[23:0];
                     pos_in = cap_pos_next;
                     if (cap_done) begin
                        step_in            = STEP_START;
                        push.valid         = 1'b1;
                        push.item.quantity = Q_SOLAR_POWER;
                        if (step_ff == STEP_POWER_CAP2) begin
                           push.item.raw = {{16{cap_word[15]}}, cap_word[15:0]};
                        end else begin
                           push.item.raw = {{8{cap_word[23]}}, cap_word[23:0]};
                        end
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_LAYOUT0;
         timeout_ff <= TIMEOUT_RESET;
         step_ff    <= STEP_START;
         last_ff    <= '0;
         pos_ff     <= '0;
         cap_ff     <= '0;
         idle_ff    <= '0;
      end else begin
         kind_ff    <= kind_in;
         timeout_ff <= timeout_in;
         step_ff    <= step_in;
         last_ff    <= last_in;
         pos_ff     <= pos_in;
         cap_ff     <= cap_in;
         idle_ff    <= idle_in;
      end
   end

   // A timeout always returns the parser to the start search with a clean timer.
   a_timeout_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && (req.command == CMD_TICK) && tick_over)
         |=> ((step_ff == STEP_START) && (pos_ff == 5'd0) && (idle_ff == '0)))
      else $error("timeout did not restart the parser");

   // Results are only produced by an accepted transaction.
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> accept)
      else $error("result pushed without an accepted transaction");

endmodule

`default_nettype wire

// ----- sv/smve_queue.sv -----
//------------------------------------------------------------------------------
// SML meter value extractor queue
// Short first-in first-out queue between the parser and the scaler.
//------------------------------------------------------------------------------
`default_nettype none

module smve_queue import smve_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire smve_xfer_type  push,
   output logic                ready,
   output smve_xfer_type       head,
   input  wire logic           pop
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);

   smve_item_type     slot_ff [Depth];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign ready      = (count_ff != CNT_W'(Depth));
   assign do_push    = push.valid;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

   // The fill count never passes the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(Depth))
      else $error("queue fill count beyond depth");

   // A push never lands on a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> ready)
      else $error("push into a full queue");

endmodule

`default_nettype wire

// ----- sv/smve_back.sv -----
//------------------------------------------------------------------------------
// SML meter value extractor scaler
// Four-stage pipeline that scales the raw words by 10000 or 100, or passes them
// unscaled, truncating toward zero; holds the result for the output channel.
//------------------------------------------------------------------------------
`default_nettype none

module smve_back import smve_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire smve_xfer_type head,
   output logic               pop,
   smve_rsp_if.source         rsp
);

   // Divisor modes
   localparam logic [1:0] DIV_NONE  = 2'd0;
   localparam logic [1:0] DIV_10000 = 2'd1;
   localparam logic [1:0] DIV_100   = 2'd2;

   // Reciprocals, floor(2^32 / divisor)
   localparam logic [31:0] RECIP_10000 = 32'd429496;
   localparam logic [31:0] RECIP_100   = 32'd42949672;

   localparam int DIV_W = 14;

   function automatic logic [DIV_W-1:0] divisor(input logic [1:0] mode);
      logic [DIV_W-1:0] d;
      d = 14'd1;
      unique case (mode)
         DIV_10000: d = 14'd10000;
         DIV_100:   d = 14'd100;
         default:   d = 14'd1;
      endcase
      return d;
   endfunction

   logic                  advance;

   logic                  s1_valid_ff;
   logic [QUANTITY_W-1:0] s1_quantity_ff;
   logic                  s1_neg_ff, s1_neg_in;
   logic [31:0]           s1_mag_ff, s1_mag_in;
   logic [1:0]            s1_mode_ff, s1_mode_in;

   logic                  s2_valid_ff;
   logic [QUANTITY_W-1:0] s2_quantity_ff;
   logic                  s2_neg_ff;
   logic [31:0]           s2_mag_ff;
   logic [31:0]           s2_quot_ff, s2_quot_in;
   logic [1:0]            s2_mode_ff;
   logic [31:0]           recip;
   logic [63:0]           product;

   logic                  s3_valid_ff;
   logic [QUANTITY_W-1:0] s3_quantity_ff;
   logic                  s3_neg_ff;
   logic [31:0]           s3_quot_ff;
   logic [15:0]           s3_rem_ff, s3_rem_in;
   logic [1:0]            s3_mode_ff;
   logic [31:0]           quot_times_div;

   logic                  out_valid_ff;
   logic [QUANTITY_W-1:0] out_quantity_ff;
   logic [31:0]           out_value_ff, out_value_in;
   logic [31:0]           quot_fixed;
   logic [DIV_W-1:0]      s3_div;

   // The whole pipeline moves when the output register is free or being taken.
   assign advance = !out_valid_ff || rsp.ready;
   assign pop     = advance && head.valid;

   // Stage 1: sign, magnitude and divisor mode
   always_comb begin
      s1_neg_in  = (head.item.quantity != Q_GRID_ENERGY) && head.item.raw[31];
      s1_mag_in  = s1_neg_in ? (~head.item.raw + 32'd1) : head.item.raw;
      s1_mode_in = DIV_NONE;
      unique case (head.item.quantity) inside
         Q_GRID_ENERGY, Q_SOLAR_ENERGY: s1_mode_in = DIV_10000;
         Q_SOLAR_POWER:                 s1_mode_in = DIV_100;
         default:                       s1_mode_in = DIV_NONE;
      endcase
   end

   // Stage 2: quotient estimate by reciprocal, at most one too small
   assign recip      = (s1_mode_ff == DIV_100) ? RECIP_100 : RECIP_10000;
   assign product    = s1_mag_ff * recip;
   assign s2_quot_in = (s1_mode_ff == DIV_NONE) ? s1_mag_ff : product[63:32];

   // Stage 3: remainder; it is below twice the divisor, so 16 bits are exact
   assign quot_times_div = s2_quot_ff[15:0] * {2'b00, divisor(s2_mode_ff)};
   assign s3_rem_in      = s2_mag_ff[15:0] - quot_times_div[15:0];

   // Stage 4: correct the quotient and restore the sign
   assign s3_div       = divisor(s3_mode_ff);
   assign quot_fixed   = s3_quot_ff + {31'd0, (s3_rem_ff >= {2'b00, s3_div})};
   assign out_value_in = s3_neg_ff ? (~quot_fixed + 32'd1) : quot_fixed;

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= head.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   // Data path registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_quantity_ff  <= head.item.quantity;
         s1_neg_ff       <= s1_neg_in;
         s1_mag_ff       <= s1_mag_in;
         s1_mode_ff      <= s1_mode_in;
         s2_quantity_ff  <= s1_quantity_ff;
         s2_neg_ff       <= s1_neg_ff;
         s2_mag_ff       <= s1_mag_ff;
         s2_quot_ff      <= s2_quot_in;
         s2_mode_ff      <= s1_mode_ff;
         s3_quantity_ff  <= s2_quantity_ff;
         s3_neg_ff       <= s2_neg_ff;
         s3_quot_ff      <= s2_quot_ff;
         s3_rem_ff       <= s3_rem_in;
         s3_mode_ff      <= s2_mode_ff;
         out_quantity_ff <= s3_quantity_ff;
         out_value_ff    <= out_value_in;
      end
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.quantity = out_quantity_ff;
   assign rsp.value    = $signed(out_value_ff);

   // The reciprocal estimate leaves a remainder that one correction covers.
   a_single_correction: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_rem_ff < {1'b0, s3_div, 1'b0}))
      else $error("quotient estimate off by more than one");

endmodule

`default_nettype wire

// ----- sv/sml_meter_value_extractor_top.sv -----
//------------------------------------------------------------------------------
// SML meter value extractor
// Finds the start sequence and OBIS patterns in a smart-meter SML byte stream,
// captures the value bytes and delivers energy, power and timeout results.
//------------------------------------------------------------------------------
//
//  Channel    Direction  Contents
//  req_chan   in         command (byte or millisecond tick), data_byte
//  rsp_chan   out        quantity, value (signed, scaled)
//  csr_chan   in         index (0 meter_kind, 1 timeout_ticks), data
//
//  One transaction is accepted every cycle while the queue has room; the parser
//  handles it in the cycle it is accepted. A result then passes the queue and
//  the four scaler stages (sign and magnitude, reciprocal multiply, remainder,
//  correction) to the output register. Reset is synchronous and needs no sweep.
//  A stalled result channel fills the queue; req_chan.ready drops only when it
//  is full. Configuration writes are taken every cycle.
//
//------------------------------------------------------------------------------
`default_nettype none

module sml_meter_value_extractor_top import smve_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   smve_req_if.sink   req_chan,
   smve_rsp_if.source rsp_chan,
   smve_csr_if.sink   csr_chan
);

   smve_xfer_type push;
   smve_xfer_type head;
   logic          queue_ready;
   logic          pop;

   // Parser
   smve_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .csr         (csr_chan),
      .queue_ready (queue_ready),
      .push        (push)
   );

   // Queue between parser and scaler
   smve_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .ready (queue_ready),
      .head  (head),
      .pop   (pop)
   );

   // Scaler and output register
   smve_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire
